[rtl/lfs_pkg.sv]
// lfs_pkg: shared constants, register indexes and saturation helpers
// for the line-follow steering block; no dependencies
`default_nettype none

package lfs_pkg;

    // geometry defaults of the region of interest
    localparam int LFS_IMAGE_WIDTH  = 64;
    localparam int LFS_IMAGE_HEIGHT = 24;
    localparam int LFS_TOP_ROW      = 0;
    localparam int LFS_MID_ROW      = 9;
    localparam int LFS_BOTTOM_ROW   = 23;

    // field widths
    localparam int LFS_COL_W   = 6;
    localparam int LFS_ROW_W   = 5;
    localparam int LFS_Q_W     = 16;
    localparam int LFS_SUM_W   = 32;
    localparam int LFS_IDX_W   = 3;
    localparam int LFS_STAT_W  = 2;

    // configuration reset values
    localparam logic [15:0] LFS_GAIN_P_RST    = 16'd128;
    localparam logic [15:0] LFS_GAIN_I_RST    = 16'd0;
    localparam logic [15:0] LFS_GAIN_D_RST    = 16'd13;
    localparam logic [5:0]  LFS_CENTER_RST    = 6'd32;
    localparam logic [5:0]  LFS_NEAR_RST      = 6'd2;
    localparam logic [15:0] LFS_FAST_BASE_RST = 16'd2304;
    localparam logic [15:0] LFS_SLOW_BASE_RST = 16'd1792;

    typedef enum logic [LFS_IDX_W-1:0] {
        REG_GAIN_P        = 3'd0,
        REG_GAIN_I_PERIOD = 3'd1,
        REG_GAIN_D        = 3'd2,
        REG_CENTER_COLUMN = 3'd3,
        REG_NEAR_BAND     = 3'd4,
        REG_FAST_BASE     = 3'd5,
        REG_SLOW_BASE     = 3'd6
    } reg_index_t;

    // edge status bits
    localparam int LFS_ST_LEFT_MISSING  = 0;
    localparam int LFS_ST_RIGHT_MISSING = 1;

    function automatic logic [15:0] sat16_17(input logic [16:0] x);
        logic [15:0] r;
        if (x[16:15] == 2'b00 || x[16:15] == 2'b11) begin
            r = x[15:0];
        end else begin
            r = x[16] ? 16'h8000 : 16'h7fff;
        end
        return r;
    endfunction

    function automatic logic [15:0] sat16_18(input logic [17:0] x);
        logic [15:0] r;
        if (x[17:15] == 3'b000 || x[17:15] == 3'b111) begin
            r = x[15:0];
        end else begin
            r = x[17] ? 16'h8000 : 16'h7fff;
        end
        return r;
    endfunction

    function automatic logic [15:0] sat16_42(input logic [41:0] x);
        logic [15:0] r;
        if (x[41:15] == '0 || x[41:15] == '1) begin
            r = x[15:0];
        end else begin
            r = x[41] ? 16'h8000 : 16'h7fff;
        end
        return r;
    endfunction

    function automatic logic [31:0] sat32_33(input logic [32:0] x);
        logic [31:0] r;
        if (x[32] == x[31]) begin
            r = x[31:0];
        end else begin
            r = x[32] ? 32'h8000_0000 : 32'h7fff_ffff;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/line_follow_steering.sv]
// line_follow_steering: edge tracking over a pixel stream and a pipelined
// PID steering step at frame end; depends on lfs_pkg
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | pixel_on, column, row, frame_end
//  m_      | out       | m_valid / m_ready  | left/right speed, middle column, status
//  cfg_    | in        | cfg_we (no wait)   | cfg_index, cfg_wdata
//
// pixels are taken one per cycle; s_ready only drops for a frame_end request
// while the previous frame's steering result has not yet reached the output register
// a frame_end request reaches m_valid through the input register, eight steering
// stages and the output register; the 32x17 integral product sets the depth
// reset is synchronous, active low; it clears edge records and PID history
// a stalled result waits in the output register without stopping pixel requests
`default_nettype none

module line_follow_steering #(
    parameter int IMAGE_WIDTH  = lfs_pkg::LFS_IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT = lfs_pkg::LFS_IMAGE_HEIGHT,
    parameter int TOP_ROW      = lfs_pkg::LFS_TOP_ROW,
    parameter int MID_ROW      = lfs_pkg::LFS_MID_ROW,
    parameter int BOTTOM_ROW   = lfs_pkg::LFS_BOTTOM_ROW
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // configuration
    input  wire logic                            cfg_we,
    input  wire logic [lfs_pkg::LFS_IDX_W-1:0]   cfg_index,
    input  wire logic [lfs_pkg::LFS_Q_W-1:0]     cfg_wdata,
    // pixel requests
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_pixel_on,
    input  wire logic [lfs_pkg::LFS_COL_W-1:0]   s_column,
    input  wire logic [lfs_pkg::LFS_ROW_W-1:0]   s_row,
    input  wire logic                            s_frame_end,
    // steering results
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic signed [lfs_pkg::LFS_Q_W-1:0]   m_left_speed,
    output logic signed [lfs_pkg::LFS_Q_W-1:0]   m_right_speed,
    output logic [lfs_pkg::LFS_COL_W-1:0]        m_middle_column,
    output logic [lfs_pkg::LFS_STAT_W-1:0]       m_edge_status
);
    import lfs_pkg::*;

    localparam int NSTG = 8;

    // ---------------- configuration registers ----------------
    logic [15:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [5:0]  center_reg, near_reg;
    logic [15:0] fast_base_reg, slow_base_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg    <= LFS_GAIN_P_RST;
            gain_i_reg    <= LFS_GAIN_I_RST;
            gain_d_reg    <= LFS_GAIN_D_RST;
            center_reg    <= LFS_CENTER_RST;
            near_reg      <= LFS_NEAR_RST;
            fast_base_reg <= LFS_FAST_BASE_RST;
            slow_base_reg <= LFS_SLOW_BASE_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_GAIN_P:        gain_p_reg    <= cfg_wdata;
                REG_GAIN_I_PERIOD: gain_i_reg    <= cfg_wdata;
                REG_GAIN_D:        gain_d_reg    <= cfg_wdata;
                REG_CENTER_COLUMN: center_reg    <= cfg_wdata[5:0];
                REG_NEAR_BAND:     near_reg      <= cfg_wdata[5:0];
                REG_FAST_BASE:     fast_base_reg <= cfg_wdata;
                REG_SLOW_BASE:     slow_base_reg <= cfg_wdata;
                default: ;         // unknown index, write dropped
            endcase
        end
    end

    // ---------------- input register ----------------
    logic             in_vld_reg;
    logic             in_on_reg, in_fe_reg;
    logic [5:0]       in_col_reg;
    logic [4:0]       in_row_reg;
    logic             frame_busy_reg;
    logic             s_fire;

    // only one frame is in the steering pipe at a time: its PID step needs
    // the previous frame's output
    assign s_ready = !s_frame_end || !frame_busy_reg;
    assign s_fire  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= s_fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_on_reg  <= s_pixel_on;
            in_fe_reg  <= s_frame_end;
            in_col_reg <= s_column;
            in_row_reg <= s_row;
        end
    end

    // ---------------- edge records ----------------
    logic [5:0] top_col_reg, mid_col_reg, bot_col_reg;
    logic       top_found_reg, mid_found_reg, bot_found_reg;
    logic [5:0] top_col_next, mid_col_next, bot_col_next;
    logic       top_found_next, mid_found_next, bot_found_next;
    logic       pix_hit, top_hit, mid_hit, bot_hit, frame_close;
    logic [5:0] snap_left, snap_right;
    logic [1:0] snap_status;

    assign pix_hit = in_vld_reg && in_on_reg
                  && (32'(in_col_reg) < IMAGE_WIDTH) && (32'(in_row_reg) < IMAGE_HEIGHT);
    assign top_hit = pix_hit && (32'(in_row_reg) == TOP_ROW)
                  && (!top_found_reg || in_col_reg < top_col_reg);
    assign mid_hit = pix_hit && (32'(in_row_reg) == MID_ROW)
                  && (!mid_found_reg || in_col_reg < mid_col_reg);
    assign bot_hit = pix_hit && (32'(in_row_reg) == BOTTOM_ROW)
                  && (!bot_found_reg || in_col_reg > bot_col_reg);
    assign frame_close = in_vld_reg && in_fe_reg;

    always_comb begin
        // records including the current pixel
        top_col_next   = top_hit ? in_col_reg : top_col_reg;
        mid_col_next   = mid_hit ? in_col_reg : mid_col_reg;
        bot_col_next   = bot_hit ? in_col_reg : bot_col_reg;
        top_found_next = top_found_reg || top_hit;
        mid_found_next = mid_found_reg || mid_hit;
        bot_found_next = bot_found_reg || bot_hit;

        // left edge: top row first, middle row as fallback, column 0 if none
        snap_status = '0;
        if (top_found_next) begin
            snap_left = top_col_next;
        end else if (mid_found_next) begin
            snap_left = mid_col_next;
        end else begin
            snap_left = '0;
            snap_status[LFS_ST_LEFT_MISSING] = 1'b1;
        end
        if (bot_found_next) begin
            snap_right = bot_col_next;
        end else begin
            snap_right = '0;
            snap_status[LFS_ST_RIGHT_MISSING] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_col_reg   <= '0;
            mid_col_reg   <= '0;
            bot_col_reg   <= '0;
            top_found_reg <= 1'b0;
            mid_found_reg <= 1'b0;
            bot_found_reg <= 1'b0;
        end else begin
            top_col_reg   <= top_col_next;
            mid_col_reg   <= mid_col_next;
            bot_col_reg   <= bot_col_next;
            // found flags start over after each frame
            top_found_reg <= top_found_next && !frame_close;
            mid_found_reg <= mid_found_next && !frame_close;
            bot_found_reg <= bot_found_next && !frame_close;
        end
    end

    // ---------------- steering pipeline ----------------
    // stage valid k means stage k's registers hold the frame in flight;
    // payload of earlier stages stays put until the frame leaves, so later
    // stages read it in place
    logic [NSTG:1] stg_vld_reg, stg_vld_next;
    logic          out_load;
    logic          m_valid_reg;

    assign out_load = stg_vld_reg[NSTG] && (!m_valid_reg || m_ready);

    always_comb begin
        stg_vld_next = {stg_vld_reg[NSTG-1:1], frame_close};
        stg_vld_next[NSTG] = stg_vld_reg[NSTG-1] || (stg_vld_reg[NSTG] && !out_load);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_vld_reg    <= '0;
            frame_busy_reg <= 1'b0;
        end else begin
            stg_vld_reg <= stg_vld_next;
            if (s_fire && s_frame_end) begin
                frame_busy_reg <= 1'b1;
            end else if (out_load) begin
                frame_busy_reg <= 1'b0;
            end
        end
    end

    // stage 1: edge snapshot
    logic [5:0] p1_left_reg, p1_right_reg;
    logic [1:0] p1_status_reg;
    // stage 2: midpoint, offset, base speed
    logic [5:0]         p2_middle_reg;
    logic signed [6:0]  p2_offset_reg;
    logic [15:0]        p2_base_reg;
    logic signed [6:0]  mid_diff, mid_half, p2_offset_c, p2_mag_c;
    logic [5:0]         p2_middle_c;
    // stage 3: error against last output
    logic signed [15:0] p3_err_reg;
    logic signed [17:0] err_wide;
    // stage 4: integral and derivative terms
    logic signed [31:0] p4_esum_reg;
    logic signed [16:0] p4_derr_reg;
    logic signed [32:0] esum_wide;
    logic signed [16:0] derr_c;
    // stage 5: products
    logic signed [32:0] p5_mp_reg;
    logic signed [48:0] p5_mi_reg;
    logic signed [33:0] p5_md_reg;
    // stage 6/7: accumulation with rounding offset
    logic signed [34:0] p6_pd_reg;
    logic signed [49:0] p7_acc_reg;
    // stage 8: PID output
    logic signed [15:0] p8_pid_reg;
    // PID history
    logic signed [31:0] error_sum_reg;
    logic signed [15:0] prev_err_reg, prev_out_reg;

    always_comb begin
        // midpoint, quotient truncated toward zero
        mid_diff    = $signed({1'b0, p1_right_reg}) - $signed({1'b0, p1_left_reg});
        mid_half    = (mid_diff + $signed({6'd0, mid_diff[6]})) >>> 1;
        p2_middle_c = p1_left_reg + mid_half[5:0];
        p2_offset_c = $signed({1'b0, p2_middle_c}) - $signed({1'b0, center_reg});
        p2_mag_c    = p2_offset_c[6] ? -p2_offset_c : p2_offset_c;
    end

    assign err_wide  = {{3{p2_offset_reg[6]}}, p2_offset_reg, 8'd0}
                     - {{2{prev_out_reg[15]}}, prev_out_reg};
    assign esum_wide = {error_sum_reg[31], error_sum_reg}
                     + {{17{p3_err_reg[15]}}, p3_err_reg};
    assign derr_c    = {p3_err_reg[15], p3_err_reg} - {prev_err_reg[15], prev_err_reg};

    always_ff @(posedge aclk) begin
        if (frame_close) begin
            p1_left_reg   <= snap_left;
            p1_right_reg  <= snap_right;
            p1_status_reg <= snap_status;
        end
        if (stg_vld_reg[1]) begin
            p2_middle_reg <= p2_middle_c;
            p2_offset_reg <= p2_offset_c;
            p2_base_reg   <= ({1'b0, p2_mag_c[5:0]} <= {1'b0, near_reg})
                             ? fast_base_reg : slow_base_reg;
        end
        if (stg_vld_reg[2]) begin
            p3_err_reg <= $signed(sat16_18(err_wide));
        end
        if (stg_vld_reg[3]) begin
            p4_esum_reg <= $signed(sat32_33(esum_wide));
            p4_derr_reg <= derr_c;
        end
        if (stg_vld_reg[4]) begin
            p5_mp_reg <= p3_err_reg * $signed({1'b0, gain_p_reg});
            p5_mi_reg <= p4_esum_reg * $signed({1'b0, gain_i_reg});
            p5_md_reg <= p4_derr_reg * $signed({1'b0, gain_d_reg});
        end
        if (stg_vld_reg[5]) begin
            p6_pd_reg <= {{2{p5_mp_reg[32]}}, p5_mp_reg} + {p5_md_reg[33], p5_md_reg}
                       + 35'sd128;
        end
        if (stg_vld_reg[6]) begin
            p7_acc_reg <= {{1{p5_mi_reg[48]}}, p5_mi_reg} + {{15{p6_pd_reg[34]}}, p6_pd_reg};
        end
        if (stg_vld_reg[7]) begin
            // floor of a right shift rounds the biased sum to nearest
            p8_pid_reg <= $signed(sat16_42(p7_acc_reg[49:8]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            error_sum_reg <= '0;
            prev_err_reg  <= '0;
            prev_out_reg  <= '0;
        end else begin
            if (stg_vld_reg[3]) begin
                error_sum_reg <= $signed(sat32_33(esum_wide));
                prev_err_reg  <= p3_err_reg;
            end
            if (stg_vld_reg[7]) begin
                prev_out_reg <= $signed(sat16_42(p7_acc_reg[49:8]));
            end
        end
    end

    // ---------------- output register ----------------
    logic signed [15:0] half_c;
    logic signed [16:0] left_wide, right_wide;
    logic [15:0]        left_reg, right_reg;
    logic [5:0]         middle_reg;
    logic [1:0]         status_reg;

    assign half_c     = p8_pid_reg >>> 1;
    assign left_wide  = {p2_base_reg[15], p2_base_reg} + {half_c[15], half_c};
    assign right_wide = {p2_base_reg[15], p2_base_reg} - {half_c[15], half_c};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            left_reg   <= sat16_17(left_wide);
            right_reg  <= sat16_17(right_wide);
            middle_reg <= p2_middle_reg;
            status_reg <= p1_status_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_left_speed    = $signed(left_reg);
    assign m_right_speed   = $signed(right_reg);
    assign m_middle_column = middle_reg;
    assign m_edge_status   = status_reg;

    // ---------------- assertions ----------------
    // never more than one frame in the steering pipe
    a_one_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({frame_close, stg_vld_reg}))
        else $error("more than one frame in steering pipeline");

    // an idle block has nothing in flight
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !frame_busy_reg |-> (stg_vld_reg == '0) && !frame_close)
        else $error("steering stage active while not busy");

    // edge records start over after a frame closes
    a_found_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_close |=> !top_found_reg && !mid_found_reg && !bot_found_reg)
        else $error("found flags not cleared at frame end");

    // a result leaving the last stage shows up at the output
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid_reg && !stg_vld_reg[NSTG])
        else $error("result lost between last stage and output");

endmodule

`default_nettype wire

[bench/tb_line_follow_steering.sv]
// tb_line_follow_steering: self-checking bench for the line-follow steering block,
// with a directed pixel table, random frames, register sweeps and output back-pressure
// depends on lfs_pkg and line_follow_steering
module tb_line_follow_steering;
    import lfs_pkg::*;

    localparam int RESULT_LATENCY  = 9;
    localparam int SETTLE_CYCLES   = RESULT_LATENCY + 6;
    localparam int STALL_LIMIT     = 3000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASES          = 6;
    localparam int PHASE_PIXELS    = 235;
    localparam int DIRECTED_ROWS   = 20;

    localparam logic [LFS_IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam logic [LFS_ROW_W-1:0] ROW_TOP    = LFS_ROW_W'(LFS_TOP_ROW);
    localparam logic [LFS_ROW_W-1:0] ROW_MID    = LFS_ROW_W'(LFS_MID_ROW);
    localparam logic [LFS_ROW_W-1:0] ROW_BOTTOM = LFS_ROW_W'(LFS_BOTTOM_ROW);

    localparam logic [LFS_STAT_W-1:0] ST_BOTH_GONE =
        (2'b1 << LFS_ST_LEFT_MISSING) | (2'b1 << LFS_ST_RIGHT_MISSING);

    typedef struct packed {
        logic                 lit;
        logic [LFS_COL_W-1:0] col;
        logic [LFS_ROW_W-1:0] row;
        logic                 last;
    } pixel_t;

    typedef struct packed {
        logic signed [LFS_Q_W-1:0] left;
        logic signed [LFS_Q_W-1:0] right;
        logic [LFS_COL_W-1:0]      mid;
        logic [LFS_STAT_W-1:0]     status;
    } steer_t;

    // one line of the directed table; pinned rows carry a hand-written result
    typedef struct packed {
        pixel_t px;
        logic   pinned;
        steer_t want;
    } script_row_t;

    logic aclk = 1'b0;
    logic aresetn;
    logic cfg_we;
    logic [LFS_IDX_W-1:0] cfg_index;
    logic [LFS_Q_W-1:0] cfg_wdata;
    logic s_valid, s_ready;
    logic s_pixel_on;
    logic [LFS_COL_W-1:0] s_column;
    logic [LFS_ROW_W-1:0] s_row;
    logic s_frame_end;
    logic m_valid, m_ready;
    logic signed [LFS_Q_W-1:0] m_left_speed, m_right_speed;
    logic [LFS_COL_W-1:0] m_middle_column;
    logic [LFS_STAT_W-1:0] m_edge_status;

    line_follow_steering dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pixel_on      (s_pixel_on),
        .s_column        (s_column),
        .s_row           (s_row),
        .s_frame_end     (s_frame_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_left_speed    (m_left_speed),
        .m_right_speed   (m_right_speed),
        .m_middle_column (m_middle_column),
        .m_edge_status   (m_edge_status)
    );

    always #5 aclk = ~aclk;

    // ---------------------------------------------------------------
    // steering predictor: edge records, pid history and register copy
    // ---------------------------------------------------------------
    logic [LFS_COL_W-1:0] top_col, mid_col, bot_col;
    bit top_seen, mid_seen, bot_seen;
    longint sum_q, prev_err_q, prev_out_q;

    logic [LFS_Q_W-1:0] kp, ki, kd;
    logic [LFS_COL_W-1:0] center, band;
    logic signed [LFS_Q_W-1:0] base_fast, base_slow;

    steer_t steer_q[$];     // steering results still owed by the block

    int fail_count = 0;
    int pixels_sent = 0;
    int results_seen = 0;
    int stall_cycles = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_off_req = 1'b0;

    script_row_t directed_rows [DIRECTED_ROWS];

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // division rounding toward minus infinity
    function automatic longint floor_div(input longint v, input longint d);
        return (v >= 0) ? v / d : -((-v + d - 1) / d);
    endfunction

    // take in one pixel; returns 1 and the steering result on frame end
    function automatic bit track_pixel(input pixel_t px, output steer_t res);
        longint left_c, right_c, middle, offset, err, acc, pid, half, base, mag;
        logic [LFS_STAT_W-1:0] status;
        res = '0;
        if (px.lit && px.col < LFS_IMAGE_WIDTH && px.row < LFS_IMAGE_HEIGHT) begin
            if (px.row == ROW_TOP && (!top_seen || px.col < top_col)) begin
                top_col = px.col;
                top_seen = 1'b1;
            end
            if (px.row == ROW_MID && (!mid_seen || px.col < mid_col)) begin
                mid_col = px.col;
                mid_seen = 1'b1;
            end
            if (px.row == ROW_BOTTOM && (!bot_seen || px.col > bot_col)) begin
                bot_col = px.col;
                bot_seen = 1'b1;
            end
        end
        if (!px.last)
            return 1'b0;

        // missing edges fall back to column 0 and raise a status bit
        status = '0;
        left_c = 0;
        right_c = 0;
        if (top_seen)
            left_c = top_col;
        else if (mid_seen)
            left_c = mid_col;
        else
            status[LFS_ST_LEFT_MISSING] = 1'b1;
        if (bot_seen)
            right_c = bot_col;
        else
            status[LFS_ST_RIGHT_MISSING] = 1'b1;

        // integer division truncates toward zero here
        middle = left_c + (right_c - left_c) / 2;
        offset = middle - longint'(center);

        // pid whose measurement is its own previous output
        err = clamp(offset * 256 - prev_out_q, -32768, 32767);
        sum_q = clamp(sum_q + err, -64'sd2147483648, 64'sd2147483647);
        acc = err * longint'(kp) + sum_q * longint'(ki) + (err - prev_err_q) * longint'(kd);
        pid = clamp(floor_div(acc + 128, 256), -32768, 32767);
        prev_err_q = err;
        prev_out_q = pid;

        half = floor_div(pid, 2);
        mag = (offset < 0) ? -offset : offset;
        base = (mag <= longint'(band)) ? longint'(base_fast) : longint'(base_slow);
        res.left = LFS_Q_W'(clamp(base + half, -32768, 32767));
        res.right = LFS_Q_W'(clamp(base - half, -32768, 32767));
        res.mid = LFS_COL_W'(middle);
        res.status = status;

        top_seen = 1'b0;
        mid_seen = 1'b0;
        bot_seen = 1'b0;
        return 1'b1;
    endfunction

    task automatic note_failure(input string msg);
        $display("%0t: %s", $time, msg);
        fail_count++;
    endtask

    // ---------------------------------------------------------------
    // drivers: everything changes on the falling edge
    // ---------------------------------------------------------------

    // register write; predictor copy follows, unknown indexes are dropped
    task automatic write_reg(input logic [LFS_IDX_W-1:0] idx, input logic [LFS_Q_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_GAIN_P:        kp = val;
            REG_GAIN_I_PERIOD: ki = val;
            REG_GAIN_D:        kd = val;
            REG_CENTER_COLUMN: center = val[LFS_COL_W-1:0];
            REG_NEAR_BAND:     band = val[LFS_COL_W-1:0];
            REG_FAST_BASE:     base_fast = val;
            REG_SLOW_BASE:     base_slow = val;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // offer one pixel request and hold it until taken; valid stays up on return
    task automatic offer_pixel(input pixel_t px, input bit pinned, input steer_t want);
        steer_t res;
        bit fires;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel_on <= px.lit;
        s_column <= px.col;
        s_row <= px.row;
        s_frame_end <= px.last;
        do
            @(posedge aclk);
        while (!s_ready);
        fires = track_pixel(px, res);
        if (fires)
            steer_q.push_back(pinned ? want : res);
        pixels_sent++;
        @(negedge aclk);
    endtask

    // sender goes quiet until every owed result is out and the pipe is empty
    task automatic wait_quiet();
        s_valid <= 1'b0;
        while (steer_q.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic pixel_t random_pixel(input int lit_pct);
        pixel_t px;
        int pick;
        px.lit = ($urandom_range(99) < lit_pct);
        pick = $urandom_range(9);
        if (pick == 0)
            px.col = '0;
        else if (pick == 1)
            px.col = '1;
        else
            px.col = LFS_COL_W'($urandom_range(63));
        // edge rows dominate so the records actually get exercised
        pick = $urandom_range(99);
        if (pick < 20)
            px.row = ROW_TOP;
        else if (pick < 40)
            px.row = ROW_MID;
        else if (pick < 60)
            px.row = ROW_BOTTOM;
        else if (pick < 88)
            px.row = LFS_ROW_W'($urandom_range(LFS_IMAGE_HEIGHT - 1));
        else
            px.row = LFS_ROW_W'($urandom_range(31, LFS_IMAGE_HEIGHT));
        px.last = 1'b0;
        return px;
    endfunction

    // one frame of random pixels closed by a frame end; some frames are mostly dark
    task automatic send_random_frame(inout int sent);
        int len;
        int lit_pct;
        pixel_t px;
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 11) : $urandom_range(10, 1);
        lit_pct = ($urandom_range(9) < 2) ? 10 : 75;
        for (int k = 0; k < len; k++) begin
            px = random_pixel(lit_pct);
            px.last = (k == len - 1);
            offer_pixel(px, 1'b0, '0);
            sent++;
        end
    endtask

    // ---------------------------------------------------------------
    // receiver: random ready, or a long hold-off when asked
    // ---------------------------------------------------------------
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                // output stays blocked so frame end requests back up at the input
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
                hold_off_req = 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // ---------------------------------------------------------------
    // result checker, sampled on the rising edge
    // ---------------------------------------------------------------
    always @(posedge aclk) begin : check_result
        steer_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (steer_q.size() == 0) begin
                note_failure($sformatf("steering result with none pending (mid %0d)",
                                       m_middle_column));
            end else begin
                want = steer_q.pop_front();
                if (m_left_speed !== want.left)
                    note_failure($sformatf("left_speed got %0d want %0d",
                                           m_left_speed, want.left));
                if (m_right_speed !== want.right)
                    note_failure($sformatf("right_speed got %0d want %0d",
                                           m_right_speed, want.right));
                if (m_middle_column !== want.mid)
                    note_failure($sformatf("middle_column got %0d want %0d",
                                           m_middle_column, want.mid));
                if (m_edge_status !== want.status)
                    note_failure($sformatf("edge_status got %0d want %0d",
                                           m_edge_status, want.status));
            end
        end
    end

    // watchdog: cycles in which neither channel moves a request
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
        $display("tb_line_follow_steering: errors");
        $finish;
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial begin
        int sent;

        // directed frames, all under the reset register values
        directed_rows = '{
            // straight after reset: nothing lit, both edges missing
            '{'{1'b0, 6'd0,  ROW_TOP,    1'b1}, 1'b1,
              '{-16'sd464, 16'sd4048, 6'd0, ST_BOTH_GONE}},
            // top row wins over middle row, bottom keeps its rightmost pixel
            '{'{1'b1, 6'd10, ROW_MID,    1'b0}, 1'b0, '0},
            '{'{1'b1, 6'd40, ROW_TOP,    1'b0}, 1'b0, '0},
            '{'{1'b1, 6'd12, ROW_TOP,    1'b0}, 1'b0, '0},
            '{'{1'b1, 6'd50, ROW_BOTTOM, 1'b0}, 1'b0, '0},
            '{'{1'b1, 6'd20, ROW_BOTTOM, 1'b0}, 1'b0, '0},
            '{'{1'b1, 6'd63, ROW_BOTTOM, 1'b1}, 1'b0, '0},
            // no top edge, left comes from the middle row
            '{'{1'b1, 6'd30, ROW_MID,    1'b0}, 1'b0, '0},
            '{'{1'b1, 6'd5,  ROW_MID,    1'b0}, 1'b0, '0},
            '{'{1'b1, 6'd33, ROW_BOTTOM, 1'b1}, 1'b0, '0},
            // right edge missing; the closing pixel is dark
            '{'{1'b1, 6'd0,  ROW_TOP,    1'b0}, 1'b0, '0},
            '{'{1'b0, 6'd63, ROW_BOTTOM, 1'b1}, 1'b0, '0},
            // left edge missing, right edge at column 0
            '{'{1'b1, 6'd0,  ROW_BOTTOM, 1'b1}, 1'b0, '0},
            // rows below the image are ignored, frame end on one still closes
            '{'{1'b1, 6'd7,  5'd24,      1'b0}, 1'b0, '0},
            '{'{1'b1, 6'd63, 5'd31,      1'b1}, 1'b0, '0},
            // other rows are ignored; bottom pixel arrives before the top one
            '{'{1'b1, 6'd3,  5'd1,       1'b0}, 1'b0, '0},
            '{'{1'b1, 6'd60, 5'd22,      1'b0}, 1'b0, '0},
            '{'{1'b1, 6'd31, 5'd16,      1'b0}, 1'b0, '0},
            '{'{1'b1, 6'd62, ROW_BOTTOM, 1'b0}, 1'b0, '0},
            '{'{1'b1, 6'd1,  ROW_TOP,    1'b1}, 1'b0, '0}
        };

        // every input known from time zero
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_GAIN_P;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_pixel_on = 1'b0;
        s_column = '0;
        s_row = '0;
        s_frame_end = 1'b0;

        // predictor starts from the reset state
        top_col = '0; mid_col = '0; bot_col = '0;
        top_seen = 1'b0; mid_seen = 1'b0; bot_seen = 1'b0;
        sum_q = 0; prev_err_q = 0; prev_out_q = 0;
        kp = LFS_GAIN_P_RST;
        ki = LFS_GAIN_I_RST;
        kd = LFS_GAIN_D_RST;
        center = LFS_CENTER_RST;
        band = LFS_NEAR_RST;
        base_fast = LFS_FAST_BASE_RST;
        base_slow = LFS_SLOW_BASE_RST;

        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct = 13;
        recv_idle_pct = 50;
        for (int k = 0; k < DIRECTED_ROWS; k++)
            offer_pixel(directed_rows[k].px, directed_rows[k].pinned, directed_rows[k].want);

        for (int p = 0; p < PHASES; p++) begin
            // registers only change with nothing in flight
            wait_quiet();
            case (p)
                0: begin
                    // every register at its top value but the slow base at its most negative, plus a write to a hole
                    write_reg(REG_GAIN_P, 16'hffff);
                    write_reg(REG_GAIN_I_PERIOD, 16'hffff);
                    write_reg(REG_GAIN_D, 16'hffff);
                    write_reg(REG_CENTER_COLUMN, 16'd63);
                    write_reg(REG_NEAR_BAND, 16'd63);
                    write_reg(REG_FAST_BASE, 16'h7fff);
                    write_reg(REG_SLOW_BASE, 16'h8000);
                    write_reg(REG_UNUSED, 16'hffff);
                end
                1: begin
                    // gains off, bases at opposite rails
                    write_reg(REG_GAIN_P, 16'h0000);
                    write_reg(REG_GAIN_I_PERIOD, 16'h0000);
                    write_reg(REG_GAIN_D, 16'h0000);
                    write_reg(REG_CENTER_COLUMN, 16'd0);
                    write_reg(REG_NEAR_BAND, 16'd0);
                    write_reg(REG_FAST_BASE, 16'h8000);
                    write_reg(REG_SLOW_BASE, 16'h7fff);
                end
                default: begin
                    // moderate gains keep the loop out of saturation most of the time
                    write_reg(REG_GAIN_P, LFS_Q_W'($urandom_range(1024)));
                    write_reg(REG_GAIN_I_PERIOD, LFS_Q_W'($urandom_range(32)));
                    write_reg(REG_GAIN_D, LFS_Q_W'($urandom_range(512)));
                    write_reg(REG_CENTER_COLUMN, LFS_Q_W'($urandom_range(63)));
                    write_reg(REG_NEAR_BAND, LFS_Q_W'($urandom_range(10)));
                    write_reg(REG_FAST_BASE, LFS_Q_W'($urandom));
                    write_reg(REG_SLOW_BASE, LFS_Q_W'($urandom));
                end
            endcase
            cfg_we <= 1'b0;

            // idle pattern: sender light / receiver heavy, then swapped, then none
            case (p / 2)
                0: begin
                    send_idle_pct = 13;
                    recv_idle_pct = 50;
                end
                1: begin
                    send_idle_pct = 50;
                    recv_idle_pct = 13;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase

            // once, block the output for a long stretch while pixels keep coming
            if (p == PHASES - 2)
                hold_off_req = 1'b1;

            sent = 0;
            while (sent < PHASE_PIXELS)
                send_random_frame(sent);
        end

        wait_quiet();
        if (steer_q.size() != 0)
            note_failure($sformatf("%0d steering results never arrived", steer_q.size()));

        $display("run covered %0d pixel requests and %0d steering results", pixels_sent,
                 results_seen);
        $display("over %0d register settings incl. rails, idle mixes and a long output stall",
                 PHASES + 1);
        if (fail_count == 0)
            $display("tb_line_follow_steering: clean");
        else
            $display("tb_line_follow_steering: errors");
        $finish;
    end

endmodule

[filelist.f]
rtl/lfs_pkg.sv
rtl/line_follow_steering.sv
bench/tb_line_follow_steering.sv
